/* hw/rtl/pwlqe_pkg.sv */
// package for the piecewise linear efficiency lookup
// holds field widths, the table entry type, divider handshake structs and sequencer states
// no dependencies
`default_nettype none

package pwlqe_pkg;

	localparam int WL_W   = 16;
	localparam int EFF_W  = 16;
	localparam int DET_W  = 4;
	localparam int BIN_W  = 6;
	localparam int PROD_W = WL_W + EFF_W;

	// item function codes
	typedef enum logic [0:0] {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	// one table entry: breakpoint wavelength and efficiency at that point
	typedef struct packed {
		logic [WL_W-1:0]  bp;
		logic [EFF_W-1:0] eff;
	} entry_t;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [WL_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [EFF_W-1:0] quotient;
	} div_rsp_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LAST,
		ST_RD_FIRST,
		ST_CHECK,
		ST_SCAN,
		ST_MUL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/pwlqe_mem.sv */
// table memory: one write port, one registered read port
// entries are breakpoint/efficiency pairs; depends on pwlqe_pkg
`default_nettype none

module pwlqe_mem #(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire pwlqe_pkg::entry_t        wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output pwlqe_pkg::entry_t             rd_data
);

	pwlqe_pkg::entry_t mem [DEPTH];
	pwlqe_pkg::entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* hw/rtl/pwlqe_div.sv */
// iterative restoring divider, one quotient bit per cycle
// quotient must fit in EFF_W bits (upper dividend half below divisor); depends on pwlqe_pkg
`default_nettype none

module pwlqe_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pwlqe_pkg::div_req_t req,
	output pwlqe_pkg::div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(pwlqe_pkg::EFF_W + 1);

	logic [pwlqe_pkg::WL_W-1:0]  rem_q;
	logic [pwlqe_pkg::EFF_W-1:0] quo_q;
	logic [pwlqe_pkg::WL_W-1:0]  dvs_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [pwlqe_pkg::WL_W:0]    trial;
	logic [pwlqe_pkg::WL_W:0]    diff;
	logic                        fits;

	// shared compare and subtract
	always_comb begin
		trial = {rem_q, quo_q[pwlqe_pkg::EFF_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(pwlqe_pkg::EFF_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and shifting dividend/quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[pwlqe_pkg::PROD_W-1:pwlqe_pkg::EFF_W];
			quo_q <= req.dividend[pwlqe_pkg::EFF_W-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[pwlqe_pkg::WL_W-1:0] : trial[pwlqe_pkg::WL_W-1:0];
			quo_q <= {quo_q[pwlqe_pkg::EFF_W-2:0], fits};
		end
	end

	// response: done flag and quotient
	assign rsp = {done_q, quo_q};

endmodule

`default_nettype wire

/* hw/rtl/piecewise_linear_qe_lookup.sv */
// Piecewise linear efficiency lookup, one table of NUM_BINS breakpoints per detector.
// Input channel (in_valid/in_ready) carries one item: func selects load or query.
// A load writes one breakpoint/efficiency pair and returns one result of zero.
// A query returns the efficiency at wavelength, interpolated between breakpoints,
// with in_range set when the wavelength lies in [first, last] of the table.
// Output channel (out_valid/out_ready) carries one result per item, held in
// output registers until taken; a stalled receiver simply holds the block in
// its result state and no new item is taken meanwhile.
// A load or an invalid detector gives its result in the cycle after accept.
// A query reads the last and first entries, then scans up to NUM_BINS-1 bins
// at one table read per cycle, multiplies and runs the restoring divider
// (16 steps), then presents its result; the single table read port and the
// divider set how long a query takes.
// Items are taken one at a time: in_ready is high only while idle, so no new
// item is taken before the last result has been taken.
// Reset (arst_n low) returns the sequencer to idle; table contents are not
// cleared and must be loaded before they are queried.
// Depends on pwlqe_pkg, pwlqe_mem, pwlqe_div.
`default_nettype none

module piecewise_linear_qe_lookup #(
	parameter int NUM_DETECTORS = 16,
	parameter int NUM_BINS      = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           func,
	input  wire logic [pwlqe_pkg::DET_W-1:0]    detector_index,
	input  wire logic [pwlqe_pkg::BIN_W-1:0]    bin_index,
	input  wire logic [pwlqe_pkg::WL_W-1:0]     wavelength,
	input  wire logic [pwlqe_pkg::EFF_W-1:0]    efficiency_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [pwlqe_pkg::EFF_W-1:0]         efficiency_out,
	output logic                                in_range
);

	localparam int DEPTH  = NUM_DETECTORS * NUM_BINS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int KW     = $clog2(NUM_BINS);
	localparam logic [KW-1:0] LAST_IDX = KW'(NUM_BINS - 1);

	pwlqe_pkg::state_t state_q, state_d;

	logic [ADDR_W-1:0]              base_q;
	logic [pwlqe_pkg::WL_W-1:0]     w_q;
	pwlqe_pkg::entry_t              last_q;
	pwlqe_pkg::entry_t              lo_q;
	pwlqe_pkg::entry_t              hi_q;
	logic [KW-1:0]                  hi_idx_q;
	logic [pwlqe_pkg::PROD_W-1:0]   prod_q;
	logic [pwlqe_pkg::WL_W-1:0]     span_q;
	logic                           neg_q;
	logic [pwlqe_pkg::EFF_W-1:0]    eff_q;
	logic                           inr_q;

	logic                           accept;
	logic                           is_load;
	logic                           det_ok;
	logic                           bin_ok;
	logic                           mem_we;
	logic [ADDR_W-1:0]              wr_addr;
	logic [ADDR_W-1:0]              rd_addr;
	pwlqe_pkg::entry_t              wr_entry;
	pwlqe_pkg::entry_t              rd_entry;
	pwlqe_pkg::div_req_t            div_req;
	pwlqe_pkg::div_rsp_t            div_rsp;

	logic                           hit_last;
	logic                           hit_first;
	logic                           in_span;
	logic                           bin_hit;
	logic [pwlqe_pkg::EFF_W-1:0]    abs_d;
	logic [pwlqe_pkg::WL_W-1:0]     dw;
	logic signed [pwlqe_pkg::EFF_W+1:0] res_sum;
	logic [pwlqe_pkg::EFF_W-1:0]    res_sat;

	// input decode
	always_comb begin
		accept   = in_valid && in_ready;
		is_load  = func == pwlqe_pkg::FUNC_LOAD;
		det_ok   = 32'(detector_index) < 32'(NUM_DETECTORS);
		bin_ok   = 32'(bin_index) < 32'(NUM_BINS);
		mem_we   = accept && is_load && det_ok && bin_ok;
		wr_addr  = ADDR_W'(32'(detector_index) * 32'(NUM_BINS) + 32'(bin_index));
		wr_entry.bp  = wavelength;
		wr_entry.eff = efficiency_in;
	end

	// table compares
	always_comb begin
		hit_last  = w_q == last_q.bp;
		hit_first = w_q == rd_entry.bp;
		in_span   = (w_q >= rd_entry.bp) && (w_q < last_q.bp);
		bin_hit   = (w_q >= lo_q.bp) && (w_q < rd_entry.bp);
	end

	// interpolation operands
	always_comb begin
		abs_d = (hi_q.eff >= lo_q.eff) ? (hi_q.eff - lo_q.eff) : (lo_q.eff - hi_q.eff);
		dw    = w_q - lo_q.bp;
	end

	// final add toward the lower entry, saturated to the efficiency range
	always_comb begin
		if (neg_q) begin
			res_sum = $signed({2'b00, lo_q.eff}) - $signed({2'b00, div_rsp.quotient});
		end else begin
			res_sum = $signed({2'b00, lo_q.eff}) + $signed({2'b00, div_rsp.quotient});
		end
		if (res_sum[pwlqe_pkg::EFF_W+1]) begin
			res_sat = '0;
		end else if (res_sum[pwlqe_pkg::EFF_W]) begin
			res_sat = '1;
		end else begin
			res_sat = res_sum[pwlqe_pkg::EFF_W-1:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwlqe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, read address and handshake outputs
	always_comb begin
		state_d          = state_q;
		rd_addr          = base_q;
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = span_q;
		in_ready         = 1'b0;
		out_valid        = 1'b0;
		unique case (state_q)
			pwlqe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (is_load || !det_ok) begin
						state_d = pwlqe_pkg::ST_RESULT;
					end else begin
						state_d = pwlqe_pkg::ST_RD_LAST;
					end
				end
			end
			pwlqe_pkg::ST_RD_LAST: begin
				rd_addr = base_q + ADDR_W'(NUM_BINS - 1);
				state_d = pwlqe_pkg::ST_RD_FIRST;
			end
			pwlqe_pkg::ST_RD_FIRST: begin
				rd_addr = base_q;
				state_d = pwlqe_pkg::ST_CHECK;
			end
			pwlqe_pkg::ST_CHECK: begin
				rd_addr = base_q + ADDR_W'(1);
				if (hit_last || hit_first || !in_span) begin
					state_d = pwlqe_pkg::ST_RESULT;
				end else begin
					state_d = pwlqe_pkg::ST_SCAN;
				end
			end
			pwlqe_pkg::ST_SCAN: begin
				if (hi_idx_q == LAST_IDX) begin
					rd_addr = base_q + ADDR_W'(hi_idx_q);
				end else begin
					rd_addr = base_q + ADDR_W'(hi_idx_q) + ADDR_W'(1);
				end
				if (bin_hit) begin
					state_d = pwlqe_pkg::ST_MUL;
				end else if (hi_idx_q == LAST_IDX) begin
					state_d = pwlqe_pkg::ST_RESULT;
				end
			end
			pwlqe_pkg::ST_MUL: begin
				state_d = pwlqe_pkg::ST_DIV_START;
			end
			pwlqe_pkg::ST_DIV_START: begin
				div_req.start = 1'b1;
				state_d       = pwlqe_pkg::ST_DIV_WAIT;
			end
			pwlqe_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = pwlqe_pkg::ST_RESULT;
				end
			end
			pwlqe_pkg::ST_RESULT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = pwlqe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pwlqe_pkg::ST_IDLE;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pwlqe_pkg::ST_IDLE: begin
				if (accept) begin
					base_q <= ADDR_W'(32'(detector_index) * 32'(NUM_BINS));
					w_q    <= wavelength;
					eff_q  <= '0;
					inr_q  <= 1'b0;
				end
			end
			pwlqe_pkg::ST_RD_FIRST: begin
				last_q <= rd_entry;
			end
			pwlqe_pkg::ST_CHECK: begin
				lo_q     <= rd_entry;
				hi_idx_q <= KW'(1);
				if (hit_last) begin
					eff_q <= last_q.eff;
					inr_q <= 1'b1;
				end else if (hit_first) begin
					eff_q <= rd_entry.eff;
					inr_q <= 1'b1;
				end else if (in_span) begin
					inr_q <= 1'b1;
				end
			end
			pwlqe_pkg::ST_SCAN: begin
				if (bin_hit) begin
					hi_q <= rd_entry;
				end else begin
					lo_q     <= rd_entry;
					hi_idx_q <= hi_idx_q + KW'(1);
				end
			end
			pwlqe_pkg::ST_MUL: begin
				prod_q <= pwlqe_pkg::PROD_W'(abs_d) * pwlqe_pkg::PROD_W'(dw);
				span_q <= hi_q.bp - lo_q.bp;
				neg_q  <= hi_q.eff < lo_q.eff;
			end
			pwlqe_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					eff_q <= res_sat;
				end
			end
			default: begin
			end
		endcase
	end

	// table storage
	pwlqe_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	// shared divider
	pwlqe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign efficiency_out = eff_q;
	assign in_range       = inr_q;

endmodule

`default_nettype wire

/* hw/rtl/pwlqe_chk.sv */
// port-level checker for piecewise_linear_qe_lookup, attached by bind
// depends on piecewise_linear_qe_lookup port names only
`default_nettype none

module pwlqe_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        func,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] efficiency_out,
	input wire logic        in_range
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(efficiency_out) && $stable(in_range))
		else $error("result changed while stalled");

	// one item at a time: no new item while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

	// a load item gives a zero result in the next cycle
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !func |=> out_valid && efficiency_out == 16'd0 && !in_range)
		else $error("load item result wrong");

	// out of range results carry zero efficiency
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> efficiency_out == 16'd0)
		else $error("nonzero efficiency with in_range low");

	// after a result is taken the block is ready again
	a_ready_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready && !out_valid)
		else $error("not ready after result taken");

endmodule

bind piecewise_linear_qe_lookup pwlqe_chk u_pwlqe_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.func           (func),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.efficiency_out (efficiency_out),
	.in_range       (in_range)
);

`default_nettype wire
